// ===== rtl/core/glyph_cache_lfu_lookup_assert.svh =====
// assertion macros for the glyph cache lookup block
// expects clk_i and rst_ni in the scope of each use
`ifndef GLYPH_CACHE_LFU_LOOKUP_ASSERT_SVH
`define GLYPH_CACHE_LFU_LOOKUP_ASSERT_SVH

`ifndef SYNTH

// property that must hold at every edge out of reset
`define GCL_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("glyph cache assertion failed");

// same-cycle implication
`define GCL_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glyph cache implication failed");

// next-cycle implication
`define GCL_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glyph cache next-cycle check failed");

`else

`define GCL_ASSERT(name, prop)
`define GCL_ASSERT_IMP(name, ante, cons)
`define GCL_ASSERT_NXT(name, ante, cons)

`endif

`endif

// ===== rtl/core/gcl_pkg.sv =====
// shared types and constants for the glyph cache lookup block
// no dependencies
`timescale 1ns / 1ps

package gcl_pkg;

  // default geometry
  localparam int CACHE_ENTRIES = 16;
  localparam int MAX_COUNT     = 255;

  // fixed field widths
  localparam int CODE_W  = 8;
  localparam int COUNT_W = 8;
  localparam int SLOT_W  = 4;

  // result status codes
  typedef enum logic [1:0] {
    ST_HIT     = 2'd0,
    ST_FILL    = 2'd1,
    ST_REPLACE = 2'd2,
    ST_NOGLYPH = 2'd3
  } status_e;

  // input beat
  typedef struct packed {
    logic [CODE_W-1:0] char_code;
    logic              glyph_available;
  } in_t;

  // result beat
  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot_index;
    logic [CODE_W-1:0] evicted_code;
  } out_t;

endpackage

// ===== rtl/core/glyph_cache_lfu_lookup.sv =====
// top level of the glyph cache lookup block: sequencer, valid bits, result register
// depends on gcl_pkg, gcl_ram and glyph_cache_lfu_lookup_assert.svh
//
//  channel | signals                           | beat moves when
//  --------+-----------------------------------+---------------------------
//  in      | in_valid_i in_ready_o in_data_i   | in_valid_i & in_ready_o
//  out     | out_valid_o out_ready_i out_data_o| out_valid_o & out_ready_i
//
// a lookup runs scan, decide and emit for a hit, a fill or a miss
// without glyph, and scan, decide, age, fix and emit for a replacement with aging;
// the scan and age passes step through every entry via the count and code ram read port
// reset clears the per-entry valid bits at once; no clearing pass is needed
// in_ready_o is high only between lookups; a result waiting at the output
// does not block the next lookup until that lookup itself finishes
`timescale 1ns / 1ps

`include "glyph_cache_lfu_lookup_assert.svh"

module glyph_cache_lfu_lookup #(
  parameter int CacheEntries = gcl_pkg::CACHE_ENTRIES,
  parameter int MaxCount     = gcl_pkg::MAX_COUNT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gcl_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gcl_pkg::out_t out_data_o
);

  localparam int IW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int CW = $clog2(CacheEntries + 1);
  localparam int CNW = gcl_pkg::COUNT_W;
  localparam int CDW = gcl_pkg::CODE_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_AGE,
    S_FIX,
    S_EMIT
  } state_e;

  state_e                 state_q, state_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [CDW-1:0]         key_q, key_d;
  logic                   avail_q, avail_d;
  logic                   hit_fnd_q, hit_fnd_d;
  logic [IW-1:0]          hit_idx_q, hit_idx_d;
  logic [CNW-1:0]         hit_cnt_q, hit_cnt_d;
  logic                   emp_fnd_q, emp_fnd_d;
  logic [IW-1:0]          emp_idx_q, emp_idx_d;
  logic                   low_fnd_q, low_fnd_d;
  logic [IW-1:0]          low_idx_q, low_idx_d;
  logic [CNW-1:0]         low_cnt_q, low_cnt_d;
  logic [CDW-1:0]         low_code_q, low_code_d;
  logic [CacheEntries-1:0] vld_q, vld_d;
  logic                   rd_vld_q, rd_vld_d;
  gcl_pkg::out_t          res_q, res_d;
  gcl_pkg::out_t          out_q, out_d;
  logic                   out_valid_q, out_valid_d;

  // ram ports
  logic [IW-1:0]  raddr;
  logic [IW-1:0]  waddr;
  logic           cnt_we;
  logic [CNW-1:0] cnt_wdata;
  logic [CNW-1:0] cnt_rdata;
  logic           code_we;
  logic [CDW-1:0] code_rdata;

  // shared compare and subtract unit operands
  logic [IW-1:0]  proc_idx;
  logic [CNW-1:0] cnt_eff;
  logic [CNW-1:0] decr;
  logic           idx_last;

  assign proc_idx = IW'(idx_q - CW'(1));
  assign cnt_eff  = rd_vld_q ? cnt_rdata : '0;
  assign decr     = low_cnt_q - CNW'(1);
  assign idx_last = (idx_q == CW'(CacheEntries));
  assign raddr    = (idx_q < CW'(CacheEntries)) ? idx_q[IW-1:0] : '0;
  assign rd_vld_d = vld_q[raddr];

  gcl_ram #(
    .Width(CNW),
    .Depth(CacheEntries)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(raddr),
    .rdata_o(cnt_rdata)
  );

  gcl_ram #(
    .Width(CDW),
    .Depth(CacheEntries)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (code_we),
    .waddr_i(waddr),
    .wdata_i(key_q),
    .raddr_i(raddr),
    .rdata_o(code_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    key_d       = key_q;
    avail_d     = avail_q;
    hit_fnd_d   = hit_fnd_q;
    hit_idx_d   = hit_idx_q;
    hit_cnt_d   = hit_cnt_q;
    emp_fnd_d   = emp_fnd_q;
    emp_idx_d   = emp_idx_q;
    low_fnd_d   = low_fnd_q;
    low_idx_d   = low_idx_q;
    low_cnt_d   = low_cnt_q;
    low_code_d  = low_code_q;
    vld_d       = vld_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    waddr       = '0;
    cnt_we      = 1'b0;
    cnt_wdata   = '0;
    code_we     = 1'b0;

    // result beat taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          key_d     = in_data_i.char_code;
          avail_d   = in_data_i.glyph_available;
          hit_fnd_d = 1'b0;
          emp_fnd_d = 1'b0;
          low_fnd_d = 1'b0;
          idx_d     = '0;
          state_d   = S_SCAN;
        end
      end

      // one entry per cycle: match, first empty, first lowest count
      S_SCAN: begin
        idx_d = idx_q + CW'(1);
        if (idx_q != '0) begin
          if (!hit_fnd_q && cnt_eff != '0 && code_rdata == key_q) begin
            hit_fnd_d = 1'b1;
            hit_idx_d = proc_idx;
            hit_cnt_d = cnt_eff;
          end
          if (!emp_fnd_q && cnt_eff == '0) begin
            emp_fnd_d = 1'b1;
            emp_idx_d = proc_idx;
          end
          if (!low_fnd_q || cnt_eff < low_cnt_q) begin
            low_fnd_d  = 1'b1;
            low_cnt_d  = cnt_eff;
            low_idx_d  = proc_idx;
            low_code_d = code_rdata;
          end
        end
        if (idx_last) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_d = S_EMIT;
        if (hit_fnd_q) begin
          // saturating count raise
          waddr     = hit_idx_q;
          cnt_we    = 1'b1;
          cnt_wdata = (hit_cnt_q < CNW'(MaxCount)) ? hit_cnt_q + CNW'(1) : hit_cnt_q;
          res_d.status       = gcl_pkg::ST_HIT;
          res_d.slot_index   = gcl_pkg::SLOT_W'(hit_idx_q);
          res_d.evicted_code = '0;
        end else if (!avail_q) begin
          res_d.status       = gcl_pkg::ST_NOGLYPH;
          res_d.slot_index   = '0;
          res_d.evicted_code = '0;
        end else if (emp_fnd_q) begin
          waddr            = emp_idx_q;
          cnt_we           = 1'b1;
          cnt_wdata        = CNW'(1);
          code_we          = 1'b1;
          vld_d[emp_idx_q] = 1'b1;
          res_d.status       = gcl_pkg::ST_FILL;
          res_d.slot_index   = gcl_pkg::SLOT_W'(emp_idx_q);
          res_d.evicted_code = '0;
        end else begin
          res_d.status       = gcl_pkg::ST_REPLACE;
          res_d.slot_index   = gcl_pkg::SLOT_W'(low_idx_q);
          res_d.evicted_code = low_code_q;
          if (low_cnt_q > CNW'(1)) begin
            idx_d   = '0;
            state_d = S_AGE;
          end else begin
            waddr     = low_idx_q;
            cnt_we    = 1'b1;
            cnt_wdata = CNW'(1);
            code_we   = 1'b1;
          end
        end
      end

      // read-modify-write: each count above the victim's count minus one drops by that amount, except the victim's
      S_AGE: begin
        idx_d = idx_q + CW'(1);
        if (idx_q != '0 && proc_idx != low_idx_q && cnt_eff > decr) begin
          waddr     = proc_idx;
          cnt_we    = 1'b1;
          cnt_wdata = cnt_eff - decr;
        end
        if (idx_last) begin
          state_d = S_FIX;
        end
      end

      // install the new code in the victim slot
      S_FIX: begin
        waddr     = low_idx_q;
        cnt_we    = 1'b1;
        cnt_wdata = CNW'(1);
        code_we   = 1'b1;
        state_d   = S_EMIT;
      end

      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      hit_fnd_q   <= 1'b0;
      emp_fnd_q   <= 1'b0;
      low_fnd_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
      hit_fnd_q   <= hit_fnd_d;
      emp_fnd_q   <= emp_fnd_d;
      low_fnd_q   <= low_fnd_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    avail_q    <= avail_d;
    hit_idx_q  <= hit_idx_d;
    hit_cnt_q  <= hit_cnt_d;
    emp_idx_q  <= emp_idx_d;
    low_idx_q  <= low_idx_d;
    low_cnt_q  <= low_cnt_d;
    low_code_q <= low_code_d;
    rd_vld_q   <= rd_vld_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  `GCL_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)
  `GCL_ASSERT_IMP(a_noglyph_zero, out_valid_o && out_data_o.status == gcl_pkg::ST_NOGLYPH,
                  out_data_o.slot_index == '0 && out_data_o.evicted_code == '0)
  `GCL_ASSERT_IMP(a_no_evict_code,
                  out_valid_o && (out_data_o.status == gcl_pkg::ST_HIT ||
                                  out_data_o.status == gcl_pkg::ST_FILL),
                  out_data_o.evicted_code == '0)
  `GCL_ASSERT_IMP(a_age_skips_victim, cnt_we && state_q == S_AGE, waddr != low_idx_q)

endmodule

// ===== rtl/core/gcl_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module gcl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
